>>> hw/rtl/srtt_pkg.sv
package srtt_pkg;

    localparam int FdSlots     = 1024;
    localparam int RegionSlots = 128;
    localparam int FdW         = 10;
    localparam int FdIdxW      = $clog2(FdSlots);
    localparam int RegIdxW     = $clog2(RegionSlots);
    localparam int RegCntW     = $clog2(RegionSlots + 1);
    localparam int AddrW       = 64;
    localparam int LenW        = 32;
    localparam int QDepth      = 2;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_OTHER = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        FE_IDLE = 2'd0,
        FE_LOOK = 2'd1,
        FE_PUSH = 2'd2,
        FE_CLR  = 2'd3
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_IDLE = 2'd0,
        BE_SCAN = 2'd1,
        BE_DONE = 2'd2
    } be_state_t;

    typedef struct packed {
        req_t             kind;
        logic             sec;
        logic             hit;
        logic [AddrW-1:0] lo;
        logic [AddrW-1:0] hi;
    } job_t;

endpackage

>>> hw/rtl/srtt_front.sv
module srtt_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            req_type,
    input  logic [9:0]            fd,
    input  logic [63:0]           buf_addr,
    input  logic [31:0]           buf_len,
    input  logic                  path_secure,
    output logic                  busy,
    output logic                  push,
    output srtt_pkg::job_t        job,
    input  logic                  q_full
);
    import srtt_pkg::*;

    logic                    sec_mem [FdSlots];
    logic                    ins_mem [FdSlots];
    logic                    sec_rd, ins_rd;
    logic [FdIdxW-1:0]       clr_reg;
    fe_state_t               state_reg, state_next;
    req_t                    kind_reg;
    logic [FdW-1:0]          fd_reg;
    logic                    ps_reg;
    logic [AddrW-1:0]        lo_reg, hi_reg;
    logic                    sec_reg, hit_reg;
    logic [AddrW:0]          sum;
    logic                    in_range;
    logic                    hit_c, sec_c;
    logic                    sec_we, ins_we, sec_wd, ins_wd;
    logic                    kind_rw;
    logic [FdIdxW-1:0]       idx;
    logic [FdIdxW-1:0]       wa;

    assign idx      = fd_reg[FdIdxW-1:0];
    assign wa       = (state_reg == FE_CLR) ? clr_reg : idx;
    assign in_range = (FdW > FdIdxW) ? (fd_reg < FdW'(FdSlots)) : 1'b1;
    assign sum      = {1'b0, buf_addr} + {{(AddrW-LenW+1){1'b0}}, buf_len};
    assign kind_rw  = (kind_reg == REQ_READ) || (kind_reg == REQ_WRITE);

    always_comb
    begin
        state_next = state_reg;
        hit_c  = 1'b0;
        sec_c  = ps_reg;
        sec_we = 1'b0;
        ins_we = 1'b0;
        sec_wd = 1'b0;
        ins_wd = 1'b0;
        push   = 1'b0;
        case (state_reg)
            FE_CLR:
            begin
                sec_we = 1'b1;
                ins_we = 1'b1;
                if (clr_reg == FdIdxW'(FdSlots - 1))
                    state_next = FE_IDLE;
            end
            FE_IDLE:
            begin
                if (start)
                    state_next = FE_LOOK;
            end
            FE_LOOK:
            begin
                if (kind_rw && in_range) begin
                    if (sec_rd) begin
                        hit_c = 1'b1;
                        sec_c = 1'b1;
                    end else if (ins_rd) begin
                        hit_c = 1'b1;
                        sec_c = 1'b0;
                    end else begin
                        sec_we = 1'b1;
                        ins_we = 1'b1;
                        sec_wd = ps_reg;
                        ins_wd = ~ps_reg;
                    end
                end else if (kind_reg == REQ_CLOSE && in_range) begin
                    sec_we = 1'b1;
                    ins_we = 1'b1;
                end
                state_next = FE_PUSH;
            end
            FE_PUSH:
            begin
                if (!q_full) begin
                    push       = 1'b1;
                    state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= FE_CLR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == FE_CLR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FE_IDLE && start) begin
            kind_reg <= req_t'(req_type);
            fd_reg   <= fd;
            ps_reg   <= path_secure;
            lo_reg   <= buf_addr;
            hi_reg   <= sum[AddrW] ? {AddrW{1'b1}} : sum[AddrW-1:0];
            sec_rd   <= sec_mem[fd[FdIdxW-1:0]];
            ins_rd   <= ins_mem[fd[FdIdxW-1:0]];
        end
        if (sec_we)
            sec_mem[wa] <= sec_wd;
        if (ins_we)
            ins_mem[wa] <= ins_wd;
        if (state_reg == FE_LOOK) begin
            sec_reg <= kind_rw ? sec_c : 1'b0;
            hit_reg <= kind_rw ? hit_c : 1'b0;
        end
    end

    assign job  = '{kind: kind_reg, sec: sec_reg, hit: hit_reg, lo: lo_reg, hi: hi_reg};
    assign busy = (state_reg != FE_IDLE);

endmodule

>>> hw/rtl/srtt_queue.sv
module srtt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  srtt_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output srtt_pkg::job_t rdata,
    output logic           not_empty
);
    import srtt_pkg::*;

    localparam int PtrW = $clog2(QDepth);

    job_t            mem_reg [QDepth];
    logic [PtrW-1:0] wp_reg, rp_reg;
    logic [PtrW:0]   cnt_reg;

    assign full      = (cnt_reg == (PtrW+1)'(QDepth));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

endmodule

>>> hw/rtl/srtt_back.sv
module srtt_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  srtt_pkg::job_t job,
    output logic           pop,
    output logic           done,
    output logic           fd_is_secure,
    output logic           cache_hit,
    output logic           leak,
    output logic           table_full
);
    import srtt_pkg::*;

    logic [AddrW-1:0]       lo_mem [RegionSlots];
    logic [AddrW-1:0]       hi_mem [RegionSlots];
    logic [AddrW-1:0]       lo_rd, hi_rd;
    logic [RegCntW-1:0]     used_reg;
    logic [RegCntW-1:0]     ptr_reg, ptr_next;
    logic                   rd_v_reg, rd_v_next;
    be_state_t              state_reg, state_next;
    job_t                   cur_reg;
    logic                   leak_reg, leak_next, full_reg, full_next, wr_en;
    logic                   take;

    // regions fill in order, so used slots are 0..used_reg-1
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        rd_v_next  = 1'b0;
        leak_next  = leak_reg;
        full_next  = full_reg;
        wr_en      = 1'b0;
        take       = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                if (q_valid) begin
                    take      = 1'b1;
                    leak_next = 1'b0;
                    full_next = 1'b0;
                    ptr_next  = '0;
                    if (job.kind == REQ_WRITE && !job.sec)
                        state_next = BE_SCAN;
                    else begin
                        if (job.kind == REQ_READ && job.sec) begin
                            if (used_reg == RegCntW'(RegionSlots))
                                full_next = 1'b1;
                            else
                                wr_en = 1'b1;
                        end
                        state_next = BE_DONE;
                    end
                end
            end
            BE_SCAN:
            begin
                if (rd_v_reg && cur_reg.lo <= hi_rd && lo_rd <= cur_reg.hi)
                    leak_next = 1'b1;
                if (ptr_reg < used_reg) begin
                    rd_v_next = 1'b1;
                    ptr_next  = ptr_reg + 1'b1;
                end else if (!rd_v_reg)
                    state_next = BE_DONE;
            end
            BE_DONE: state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= BE_IDLE;
            used_reg  <= '0;
            ptr_reg   <= '0;
            rd_v_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            rd_v_reg  <= rd_v_next;
            if (wr_en)
                used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        leak_reg <= leak_next;
        full_reg <= full_next;
        if (take)
            cur_reg <= job;
        if (wr_en) begin
            lo_mem[used_reg[RegIdxW-1:0]] <= job.lo;
            hi_mem[used_reg[RegIdxW-1:0]] <= job.hi;
        end
        lo_rd <= lo_mem[ptr_reg[RegIdxW-1:0]];
        hi_rd <= hi_mem[ptr_reg[RegIdxW-1:0]];
    end

    assign pop          = take;
    assign done         = (state_reg == BE_DONE);
    assign fd_is_secure = cur_reg.sec;
    assign cache_hit    = cur_reg.hit;
    assign leak         = leak_reg;
    assign table_full   = full_reg;

endmodule

>>> hw/rtl/secure_region_taint_tracker.sv
// An accepted transaction passes the front end (look-up, push), the queue and the back end
// before done; insecure writes add a scan of the used regions, bounded by RegionSlots.
// The front accepts a new transaction only once the last one is pushed, and waits while
// the queue is full; sustained rate is set by the back end's region scan, one slot per cycle.
// Reset (rst_n, async, active low) clears the region table; busy then stays high
// while the descriptor cache is cleared. done pulses one cycle per transaction;
// the receiver cannot stall.
module secure_region_taint_tracker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [9:0]  fd,
    input  logic [63:0] buf_addr,
    input  logic [31:0] buf_len,
    input  logic        path_secure,
    output logic        done,
    output logic        fd_is_secure,
    output logic        cache_hit,
    output logic        leak,
    output logic        table_full
);
    import srtt_pkg::*;

    job_t fjob, qjob;
    logic push, q_full, pop, q_ne;

    srtt_front u_front (
        .clk, .rst_n, .start, .req_type, .fd, .buf_addr, .buf_len, .path_secure,
        .busy, .push, .job(fjob), .q_full
    );

    srtt_queue u_queue (
        .clk, .rst_n, .push, .wdata(fjob), .full(q_full),
        .pop, .rdata(qjob), .not_empty(q_ne)
    );

    srtt_back u_back (
        .clk, .rst_n, .q_valid(q_ne), .job(qjob), .pop, .done,
        .fd_is_secure, .cache_hit, .leak, .table_full
    );

endmodule

>>> hw/rtl/srtt_checker.sv
module srtt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       fd_is_secure,
    input logic       leak,
    input logic       table_full
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_leak_insecure: assert property (@(posedge clk) disable iff (!rst_n)
        done && leak |-> !fd_is_secure && !table_full) else $error("bad leak");
    a_full_secure: assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> fd_is_secure) else $error("bad table_full");
endmodule

bind secure_region_taint_tracker srtt_checker u_srtt_checker (
    .clk, .rst_n, .start, .busy, .done, .fd_is_secure, .leak, .table_full
);

>>> test/tb_top.sv
module tb_top;
    import srtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 5000;
    localparam logic [63:0] AddrMax = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic sec;
        logic hit;
        logic leak;
        logic full;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [9:0]  fd;
    logic [63:0] buf_addr;
    logic [31:0] buf_len;
    logic        path_secure;
    logic        done;
    logic        fd_is_secure;
    logic        cache_hit;
    logic        leak;
    logic        table_full;

    logic        fd_sec_cache [FdSlots];
    logic        fd_ins_cache [FdSlots];
    logic [63:0] taint_lo [RegionSlots];
    logic [63:0] taint_hi [RegionSlots];
    logic        taint_used [RegionSlots];

    verdict_t    pending_verdicts [$];
    int          error_count;
    int          idle_cycles;

    secure_region_taint_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .fd           (fd),
        .buf_addr     (buf_addr),
        .buf_len      (buf_len),
        .path_secure  (path_secure),
        .done         (done),
        .fd_is_secure (fd_is_secure),
        .cache_hit    (cache_hit),
        .leak         (leak),
        .table_full   (table_full)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic verdict_t predict_event(req_t kind, logic [9:0] d, logic [63:0] a,
                                               logic [31:0] n, logic ps);
        verdict_t    v;
        logic [64:0] sum;
        logic [63:0] hi;
        bit          placed;
        v = '0;
        sum = {1'b0, a} + {33'b0, n};
        hi = sum[64] ? AddrMax : sum[63:0];
        if (kind == REQ_READ || kind == REQ_WRITE)
        begin
            if (fd_sec_cache[d])
            begin
                v.sec = 1'b1;
                v.hit = 1'b1;
            end
            else if (fd_ins_cache[d])
                v.hit = 1'b1;
            else
            begin
                v.sec = ps;
                if (ps)
                    fd_sec_cache[d] = 1'b1;
                else
                    fd_ins_cache[d] = 1'b1;
            end
            if (kind == REQ_READ && v.sec)
            begin
                placed = 0;
                for (int i = 0; i < RegionSlots && !placed; i++)
                    if (!taint_used[i])
                    begin
                        taint_used[i] = 1'b1;
                        taint_lo[i] = a;
                        taint_hi[i] = hi;
                        placed = 1;
                    end
                v.full = !placed;
            end
            if (kind == REQ_WRITE && !v.sec)
                for (int i = 0; i < RegionSlots; i++)
                    if (taint_used[i] && a <= taint_hi[i] && taint_lo[i] <= hi)
                        v.leak = 1'b1;
        end
        else if (kind == REQ_CLOSE)
        begin
            fd_sec_cache[d] = 1'b0;
            fd_ins_cache[d] = 1'b0;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("mismatch %s: got %0b expected %0b at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_event(req_t kind, logic [9:0] d, logic [63:0] a, logic [31:0] n,
                              logic ps, bit pace = 1);
        int gap;
        gap = pace ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap + 1) @(negedge clk);
        start <= 1'b1;
        req_type <= kind;
        fd <= d;
        buf_addr <= a;
        buf_len <= n;
        path_secure <= ps;
        do
            @(posedge clk);
        while (busy);
        pending_verdicts.push_back(predict_event(kind, d, a, n, ps));
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain;
        while (pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [63:0] rand_addr;
        return {$urandom, $urandom};
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            verdict_t w;
            if (pending_verdicts.size() == 0)
            begin
                $display("unexpected transaction at %0t", $realtime);
                error_count++;
            end
            else
            begin
                w = pending_verdicts.pop_front();
                if (fd_is_secure !== w.sec)
                    report_mismatch("fd_is_secure", fd_is_secure, w.sec);
                if (cache_hit !== w.hit)
                    report_mismatch("cache_hit", cache_hit, w.hit);
                if (leak !== w.leak)
                    report_mismatch("leak", leak, w.leak);
                if (table_full !== w.full)
                    report_mismatch("table_full", table_full, w.full);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("** secure_region_taint_tracker: FAILED **");
            $finish;
        end
    end

    task automatic test_field_extremes;
        send_event(REQ_READ, 10'd0, 64'd0, 32'd0, 1'b1);
        send_event(REQ_READ, 10'd0, 64'd0, 32'd0, 1'b0);
        send_event(REQ_WRITE, 10'd1023, 64'd0, 32'd0, 1'b0);
        send_event(REQ_WRITE, 10'd1023, AddrMax, 32'hFFFF_FFFF, 1'b1);
        send_event(REQ_READ, 10'd512, AddrMax - 64'd10, 32'hFFFF_FFFF, 1'b1);
        send_event(REQ_WRITE, 10'd1023, AddrMax, 32'd0, 1'b1);
        send_event(REQ_WRITE, 10'd1023, AddrMax - 64'd11, 32'd0, 1'b0);
        send_event(REQ_OTHER, 10'd1023, AddrMax, 32'hFFFF_FFFF, 1'b1);
        send_event(REQ_CLOSE, 10'd0, AddrMax, 32'hFFFF_FFFF, 1'b1);
        send_event(REQ_WRITE, 10'd0, 64'd0, 32'd5, 1'b0);
    endtask

    task automatic test_overlap_edges;
        send_event(REQ_READ, 10'd7, 64'h1000, 32'h100, 1'b1);
        send_event(REQ_WRITE, 10'd8, 64'h0F00, 32'h100, 1'b0);
        send_event(REQ_WRITE, 10'd8, 64'h0F00, 32'h0FF, 1'b0);
        send_event(REQ_WRITE, 10'd8, 64'h1100, 32'h0, 1'b0);
        send_event(REQ_WRITE, 10'd8, 64'h1101, 32'h10, 1'b0);
        send_event(REQ_WRITE, 10'd8, 64'h0, 32'hFFFF_FFFF, 1'b1);
        send_event(REQ_WRITE, 10'd7, 64'h1050, 32'h1, 1'b0);
        send_event(REQ_CLOSE, 10'd7, 64'h0, 32'h0, 1'b0);
        send_event(REQ_WRITE, 10'd7, 64'h1050, 32'h1, 1'b0);
        drain();
    endtask

    task automatic test_random_traffic(int count);
        req_t        kind;
        logic [9:0]  d;
        logic [63:0] a;
        logic [31:0] n;
        int          r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            kind = r < 40 ? REQ_READ : r < 80 ? REQ_WRITE : r < 92 ? REQ_CLOSE : REQ_OTHER;
            d = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 15));
            r = $urandom_range(0, 9);
            a = r < 6 ? 64'($urandom_range(0, 4095)) : r < 8 ? rand_addr()
                : AddrMax - 64'($urandom_range(0, 4095));
            r = $urandom_range(0, 9);
            n = r < 6 ? 32'($urandom_range(0, 255)) : r < 8 ? 32'($urandom)
                : r < 9 ? 32'hFFFF_FFFF : 32'd0;
            send_event(kind, d, a, n, 1'($urandom), $urandom_range(0, 4) != 0);
            if (i == count / 2)
                drain();
        end
    endtask

    task automatic test_table_fill;
        for (int i = 0; i < RegionSlots + 4; i++)
            send_event(REQ_READ, 10'd900, 64'h4000_0000 + 64'(i) * 64'h100, 32'h10, 1'b1,
                       i % 8 == 0);
        send_event(REQ_WRITE, 10'd901, 64'h4000_0005, 32'h0, 1'b0);
        send_event(REQ_WRITE, 10'd901, 64'h3FFF_FFF0, 32'h8, 1'b0);
    endtask

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        start = 1'b0;
        req_type = REQ_OTHER;
        fd = '0;
        buf_addr = '0;
        buf_len = '0;
        path_secure = 1'b0;
        rst_n = 1'b0;
        for (int i = 0; i < FdSlots; i++)
        begin
            fd_sec_cache[i] = 1'b0;
            fd_ins_cache[i] = 1'b0;
        end
        for (int i = 0; i < RegionSlots; i++)
        begin
            taint_used[i] = 1'b0;
            taint_lo[i] = '0;
            taint_hi[i] = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_field_extremes();
        test_overlap_edges();
        test_random_traffic(1650);
        test_table_fill();
        drain();
        repeat (200) @(negedge clk);
        if (error_count == 0)
            $display("** secure_region_taint_tracker: PASSED **");
        else
            $display("** secure_region_taint_tracker: FAILED **");
        $finish;
    end
endmodule
